>>> sv/msig_pkg.sv
// Shared types and constants for the MinHash signature core.
package msig_pkg;

  localparam int unsigned SEED_NUM = 8;
  localparam int unsigned SEED_W   = 31;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned ADDR_W   = $clog2(SEED_NUM) + 2;
  localparam int unsigned SIDX_W   = $clog2(SEED_NUM);

  localparam logic [HASH_W-1:0]        HASH_INIT = 32'd5381;
  localparam logic signed [HASH_W-1:0] MIN_RESET = 32'sh7FFF_FFFF;

  // request codes
  localparam logic [1:0] REQ_CHAR    = 2'd0;
  localparam logic [1:0] REQ_SHINGLE = 2'd1;
  localparam logic [1:0] REQ_DOC     = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic signed [HASH_W-1:0] min_value;
    logic [2:0]               hash_index;
    logic                     empty_doc;
    logic                     last;
  } out_item_t;

  // fold -> drain snapshot control
  typedef struct packed {
    logic load;
    logic empty;
  } snap_ctl_t;

endpackage

>>> sv/msig_cfg.sv
// APB seed register file.
module msig_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [msig_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [msig_pkg::SEED_W-1:0]    seeds_o [msig_pkg::SEED_NUM]
);
  import msig_pkg::*;

  logic [SEED_W-1:0] seed_q [SEED_NUM];
  logic [SIDX_W-1:0] idx;
  logic              wr_en;

  assign idx   = paddr[ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SEED_NUM; i++) seed_q[i] <= '0;
    end else if (wr_en) begin
      seed_q[idx] <= pwdata[SEED_W-1:0];
    end
  end

  assign prdata  = {1'b0, seed_q[idx]};
  assign pready  = 1'b1;
  assign seeds_o = seed_q;

endmodule

>>> sv/msig_fold.sv
// Running djb2 hash, per-seed minimum bank and shingle flag.
module msig_fold #(
  parameter int unsigned NUM_HASHES = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              xfer_i,
  input  msig_pkg::in_item_t                item_i,
  input  logic [msig_pkg::SEED_W-1:0]       seeds_i [msig_pkg::SEED_NUM],
  output logic signed [msig_pkg::HASH_W-1:0] mins_o [NUM_HASHES],
  output msig_pkg::snap_ctl_t               snap_o
);
  import msig_pkg::*;

  logic [HASH_W-1:0]        hash_q, hash_d;
  logic signed [HASH_W-1:0] min_q [NUM_HASHES];
  logic signed [HASH_W-1:0] min_d [NUM_HASHES];
  logic signed [HASH_W-1:0] mixed [NUM_HASHES];
  logic                     have_q, have_d;

  always_comb begin
    for (int j = 0; j < NUM_HASHES; j++) begin
      mixed[j] = $signed(hash_q ^ {1'b0, seeds_i[j]});
    end
  end

  always_comb begin
    hash_d = hash_q;
    have_d = have_q;
    min_d  = min_q;
    snap_o = '0;
    if (xfer_i) begin
      case (item_i.req_type)
        REQ_CHAR: begin
          if (item_i.char_code != 8'd0) begin
            hash_d = (hash_q << 5) + hash_q + {24'd0, item_i.char_code};
          end
        end
        REQ_SHINGLE: begin
          for (int j = 0; j < NUM_HASHES; j++) begin
            if (mixed[j] < min_q[j]) min_d[j] = mixed[j];
          end
          have_d = 1'b1;
          hash_d = HASH_INIT;
        end
        REQ_DOC: begin
          snap_o.load  = 1'b1;
          snap_o.empty = !have_q;
          for (int j = 0; j < NUM_HASHES; j++) min_d[j] = MIN_RESET;
          have_d = 1'b0;
          hash_d = HASH_INIT;
        end
        default: ;  // unused code: no effect
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HASH_INIT;
      have_q <= 1'b0;
      for (int j = 0; j < NUM_HASHES; j++) min_q[j] <= MIN_RESET;
    end else begin
      hash_q <= hash_d;
      have_q <= have_d;
      min_q  <= min_d;
    end
  end

  // minimums stay at MIN_RESET while no shingle has closed
  assign mins_o = min_q;

endmodule

>>> sv/msig_drain.sv
// Signature snapshot buffer, shifted out one result per transfer.
module msig_drain #(
  parameter int unsigned NUM_HASHES = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  msig_pkg::snap_ctl_t                snap_i,
  input  logic signed [msig_pkg::HASH_W-1:0] mins_i [NUM_HASHES],
  output logic                               free_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output msig_pkg::out_item_t                out_data_o
);
  import msig_pkg::*;

  localparam int unsigned IdxW = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_HASHES - 1);

  logic signed [HASH_W-1:0] buf_q [NUM_HASHES];
  logic                     empty_q;
  logic                     busy_q;
  logic [IdxW-1:0]          cnt_q;
  logic                     xfer, xfer_last;

  assign xfer      = busy_q && out_ready_i;
  assign xfer_last = xfer && (cnt_q == LastIdx);
  // a new snapshot may land in the cycle the previous final result leaves
  assign free_o    = !busy_q || xfer_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (snap_i.load) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (xfer_last) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (xfer) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_i.load) begin
      buf_q   <= mins_i;
      empty_q <= snap_i.empty;
    end else if (xfer) begin
      for (int i = 0; i + 1 < NUM_HASHES; i++) buf_q[i] <= buf_q[i+1];
    end
  end

  assign out_valid_o           = busy_q;
  assign out_data_o.min_value  = buf_q[0];
  assign out_data_o.hash_index = 3'(cnt_q);
  assign out_data_o.empty_doc  = empty_q;
  assign out_data_o.last       = (cnt_q == LastIdx);

endmodule

>>> sv/minhash_signature_core.sv
// MinHash signature core: djb2 shingle hashing, per-seed minimums, signature drain.
// Throughput: one input item per cycle; a document close waits until the previous one's
// final result transfers. Character and shingle-close transfers update state in the cycle
// they are accepted. A document close shows the first of its NUM_HASHES results on the next
// cycle, the rest one per cycle from a single snapshot buffer while out_ready_i is high.
// Reset (rst_ni low, async): seeds 0, hash 5381, minimums 2147483647, no output pending.
module minhash_signature_core #(
  parameter int unsigned NUM_HASHES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input item channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  msig_pkg::in_item_t            in_data_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output msig_pkg::out_item_t           out_data_o,
  // APB seed registers
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msig_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import msig_pkg::*;

  logic [SEED_W-1:0]        seeds [SEED_NUM];
  logic signed [HASH_W-1:0] mins  [NUM_HASHES];
  snap_ctl_t                snap;
  logic                     buf_free;
  logic                     in_xfer;
  logic                     is_doc;

  // Only a document close needs the snapshot buffer; every other request
  // is taken each cycle, even while a signature drains.
  assign is_doc     = (in_data_i.req_type == REQ_DOC);
  assign in_ready_o = !is_doc || buf_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  msig_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .seeds_o (seeds)
  );

  // hash fold and minimum bank; all comparators update together on a shingle close
  msig_fold #(
    .NUM_HASHES (NUM_HASHES)
  ) u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .xfer_i  (in_xfer),
    .item_i  (in_data_i),
    .seeds_i (seeds),
    .mins_o  (mins),
    .snap_o  (snap)
  );

  // signature buffer; result 0 sits at the head, later ones shift toward the head per transfer
  msig_drain #(
    .NUM_HASHES (NUM_HASHES)
  ) u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .snap_i      (snap),
    .mins_i      (mins),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // a document close always starts a fresh run at index 0
  a_doc_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && is_doc |=> out_valid_o && (out_data_o.hash_index == 3'd0))
    else $error("document close did not start a result run");

  // last flag only on the final seed
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> (out_data_o.hash_index == 3'(NUM_HASHES - 1)))
    else $error("last flag on wrong seed index");

  // an empty document reports the reset minimum
  a_empty_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.empty_doc |-> (out_data_o.min_value == MIN_RESET))
    else $error("empty document with non-reset minimum");

  // snapshot never overwrites a run that is still draining
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap.load && out_valid_o |-> out_ready_i && out_data_o.last)
    else $error("signature snapshot overran pending results");

endmodule

>>> tb/minhash_signature_core_tb.sv
// Self-checking testbench for minhash_signature_core against a djb2/MinHash predictor.
module minhash_signature_core_tb;
  import msig_pkg::*;

  localparam int NUM_H      = 8;
  localparam int CYCLE_CAP  = 200000;  // far above the slowest legal run
  localparam int SETTLE_CYC = 12;      // drain margin after the last result
  localparam int ITEMS_PER_PHASE = 92; // five phases, about 460 counted requests

  // request code outside the defined set; the core must ignore it
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  // request channel
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  // signature channel
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  // APB seed port
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  minhash_signature_core #(.NUM_HASHES(NUM_H)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the seeds, running hash and minimums.
  // ---------------------------------------------------------------------------
  logic [SEED_W-1:0]        seed_val [NUM_H];
  logic [HASH_W-1:0]        dj_hash = HASH_INIT;
  logic signed [HASH_W-1:0] seed_min [NUM_H];
  bit                       doc_has_shingle = 1'b0;

  in_item_t  request_q[$];    // requests waiting to be offered to the core
  out_item_t signature_q[$];  // signature words the core still owes us

  int errors = 0;
  int cycles = 0;

  // stimulus shaping knobs, changed only between phases
  bit tx_gappy = 1'b1;
  int rx_mode  = 0;

  initial begin
    for (int j = 0; j < NUM_H; j++) begin
      seed_val[j] = '0;
      seed_min[j] = MIN_RESET;
    end
  end

  // Apply one accepted request to the predicted state. A document close
  // produces one signature word per seed, last flag on the final seed.
  function automatic void fold_request(in_item_t rq);
    logic signed [HASH_W-1:0] cand;
    out_item_t word;
    case (rq.req_type)
      REQ_CHAR: begin
        // a zero byte leaves the hash alone
        if (rq.char_code != 8'd0) dj_hash = (dj_hash << 5) + dj_hash + 32'(rq.char_code);
      end
      REQ_SHINGLE: begin
        // empty shingle still counts: it hashes to the init value
        for (int j = 0; j < NUM_H; j++) begin
          cand = dj_hash ^ {1'b0, seed_val[j]};
          if (cand < seed_min[j]) seed_min[j] = cand;
        end
        doc_has_shingle = 1'b1;
        dj_hash = HASH_INIT;
      end
      REQ_DOC: begin
        for (int j = 0; j < NUM_H; j++) begin
          word.min_value  = doc_has_shingle ? seed_min[j] : MIN_RESET;
          word.hash_index = 3'(j);
          word.empty_doc  = !doc_has_shingle;
          word.last       = (j == NUM_H - 1);
          signature_q.push_back(word);
          seed_min[j] = MIN_RESET;
        end
        // unclosed characters are dropped with the document
        doc_has_shingle = 1'b0;
        dj_hash = HASH_INIT;
      end
      default: ;  // unknown request code: no effect
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length, with random gaps between them when tx_gappy
  // is set. The predictor runs on each transfer, so expectations follow acceptance order.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : req_drv
    in_item_t nxt;
    bit       show;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) fold_request(in_data);
      // payload must hold until the transfer completes
      if (!(in_valid && !in_ready)) begin
        show = 1'b0;
        nxt  = in_data;
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          nxt  = request_q.pop_front();
          show = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = tx_gappy ? $urandom_range(1, 6) : 0;
          end
        end
        in_valid <= show;
        in_data  <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Signature monitor and receiver back-pressure.
  // ---------------------------------------------------------------------------
  int rx_tick = 0;
  int rx_hold = 0;
  bit rx_level = 1'b1;

  always @(posedge clk) begin : sig_mon
    out_item_t want;
    bit        rdy;
    if (rst_ni && out_valid && out_ready) begin
      if (signature_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer: min=%0d idx=%0d empty=%0b last=%0b",
                 $time, out_data.min_value, out_data.hash_index, out_data.empty_doc,
                 out_data.last);
      end else begin
        want = signature_q.pop_front();
        if (out_data.min_value !== want.min_value) begin
          errors++;
          $display("%0t: min_value mismatch (idx %0d): expected %0d, actual %0d",
                   $time, want.hash_index, want.min_value, out_data.min_value);
        end
        if (out_data.hash_index !== want.hash_index) begin
          errors++;
          $display("%0t: hash_index mismatch: expected %0d, actual %0d",
                   $time, want.hash_index, out_data.hash_index);
        end
        if (out_data.empty_doc !== want.empty_doc) begin
          errors++;
          $display("%0t: empty_doc mismatch (idx %0d): expected %0b, actual %0b",
                   $time, want.hash_index, want.empty_doc, out_data.empty_doc);
        end
        if (out_data.last !== want.last) begin
          errors++;
          $display("%0t: last mismatch (idx %0d): expected %0b, actual %0b",
                   $time, want.hash_index, want.last, out_data.last);
        end
      end
    end
    // ready pattern: always on, random, fixed rhythm, or long on/off stretches
    rx_tick++;
    case (rx_mode)
      0: rdy = 1'b1;
      1: rdy = ($urandom_range(0, 3) != 0);
      2: rdy = (rx_tick % 5 != 1) && (rx_tick % 7 != 3);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
        end else begin
          rx_level = !rx_level;
          rx_hold  = $urandom_range(0, 10);
        end
        rdy = rx_level;
      end
    endcase
    out_ready <= rdy;
  end

  // cycle watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("minhash_signature_core regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_req(logic [1:0] rt, logic [7:0] ch);
    in_item_t it;
    it.req_type  = rt;
    it.char_code = ch;
    request_q.push_back(it);
  endtask

  // APB write: setup then access; the seed lands on the access edge
  task automatic write_seed(logic [SIDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    seed_val[idx] = val[SEED_W-1:0];  // bit 31 is dropped by the core
  endtask

  // block until every request is taken and every signature word has arrived
  task automatic wait_idle();
    @(negedge clk);
    while (request_q.size() != 0 || in_valid || signature_q.size() != 0) @(negedge clk);
  endtask

  // One well-formed document with random content, sprinkled with noise the
  // core must ignore (zero bytes, unknown request code). Counts real requests.
  task automatic queue_random_doc(output int counted);
    int n_sh;
    int len;
    counted = 0;
    n_sh = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    for (int s = 0; s < n_sh; s++) begin
      // mostly short shingles, a few long enough to wrap the hash negative
      len = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 6);
      for (int k = 0; k < len; k++) begin
        push_req(REQ_CHAR, 8'($urandom_range(1, 255)));
        counted++;
        if ($urandom_range(0, 24) == 0) begin
          if ($urandom_range(0, 1)) push_req(REQ_UNKNOWN, 8'($urandom_range(0, 255)));
          else push_req(REQ_CHAR, 8'd0);
        end
      end
      push_req(REQ_SHINGLE, 8'($urandom_range(0, 255)));
      counted++;
    end
    // broken tail: characters left open when the document closes
    if ($urandom_range(0, 4) == 0) begin
      len = $urandom_range(1, 3);
      for (int k = 0; k < len; k++) begin
        push_req(REQ_CHAR, 8'($urandom_range(1, 255)));
        counted++;
      end
    end
    push_req(REQ_DOC, 8'($urandom_range(0, 255)));
    counted++;
  endtask

  task automatic run_random_phase();
    int done;
    int n;
    done = 0;
    while (done < ITEMS_PER_PHASE) begin
      queue_random_doc(n);
      done += n;
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;

    // Phase 0: reset seeds, directed corner cases first.
    tx_gappy = 1'b0;
    rx_mode  = 0;
    push_req(REQ_DOC, 8'h00);        // empty document
    push_req(REQ_SHINGLE, 8'h00);    // empty shingle
    push_req(REQ_DOC, 8'hFF);
    push_req(REQ_CHAR, 8'hFF);
    push_req(REQ_CHAR, 8'h01);
    push_req(REQ_CHAR, 8'h00);       // zero byte, ignored
    push_req(REQ_UNKNOWN, 8'hAA);    // unknown code, ignored
    push_req(REQ_CHAR, 8'h80);
    push_req(REQ_SHINGLE, 8'hFF);
    push_req(REQ_CHAR, 8'h7A);
    push_req(REQ_SHINGLE, 8'h00);
    push_req(REQ_CHAR, 8'h41);
    push_req(REQ_CHAR, 8'h42);       // left open at document close
    push_req(REQ_DOC, 8'h55);
    push_req(REQ_CHAR, 8'h7F);
    push_req(REQ_DOC, 8'h00);        // only open characters: still empty
    push_req(REQ_UNKNOWN, 8'h55);
    for (int k = 0; k < 6; k++) push_req(REQ_CHAR, 8'hFF);  // wraps the 32-bit hash
    push_req(REQ_SHINGLE, 8'h00);
    push_req(REQ_DOC, 8'h00);
    wait_idle();
    tx_gappy = 1'b1;
    rx_mode  = 1;
    run_random_phase();

    for (int ph = 1; ph <= 4; ph++) begin
      // core updates state on the transfer edge
      repeat (4) @(posedge clk);
      for (int j = 0; j < NUM_H; j++) begin
        case (ph)
          1: write_seed(3'(j), 32'hFFFF_FFFF);                       // top of range
          2: write_seed(3'(j), $urandom());
          3: write_seed(3'(j), (j % 3 == 0) ? 32'h0 :
                               (j % 3 == 1) ? 32'h7FFF_FFFF : $urandom());
          default: write_seed(3'(j), 32'($urandom_range(0, 255)) | ($urandom() & 32'h8000_0000));
        endcase
      end
      @(negedge clk);
      tx_gappy = (ph != 2);
      rx_mode  = ph % 4;
      run_random_phase();
    end

    repeat (SETTLE_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("minhash_signature_core regression: pass");
    end else begin
      $display("minhash_signature_core regression: fail");
    end
    $finish;
  end

endmodule

>>> minhash_signature_core.f
sv/msig_pkg.sv
sv/msig_cfg.sv
sv/msig_fold.sv
sv/msig_drain.sv
sv/minhash_signature_core.sv
tb/minhash_signature_core_tb.sv
